### rtl/assert_macros.svh
// Assertion macros for the RTL that checks itself.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("queue assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("queue assertion failed");

`endif

### rtl/spq_pkg.sv
// Types, codes and sizes of the stable priority queue.
// No dependencies; imported by spq_cell and stable_priority_queue_core.
`default_nettype none

package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int FILL_W      = 5;

	typedef enum logic {
		ACT_ENQ = 1'b0,
		ACT_DEQ = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic [7:0]         prio;
	} entry_t;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] item_data;
		logic [7:0]         item_priority;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic               head_valid;
		logic signed [31:0] head_data;
		logic [7:0]         head_priority;
		logic [FILL_W-1:0]  fill_count;
	} rsp_t;

	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t entry;
	} cell_ctl_t;

endpackage

`default_nettype wire

### rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts toward the head on
// dequeue and away from it on insert. Depends on spq_pkg.
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire logic      occ,
	input  wire logic      left_ge,
	input  wire entry_t    left_entry,
	input  wire entry_t    right_entry,
	output entry_t         entry,
	output entry_t         entry_d,
	output logic           ge
);

	entry_t entry_q;

	assign ge    = occ && (entry_q.prio >= ctl.entry.prio);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (ctl.deq) begin
			entry_d = right_entry;
		end else if (ctl.enq && !ge) begin
			entry_d = left_ge ? ctl.entry : left_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

`default_nettype wire

### rtl/stable_priority_queue_core.sv
// Top level of the stable priority queue: chain of spq_cell slots, fill
// counter and response register. Depends on spq_pkg, spq_cell, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Bounded priority queue kept sorted highest priority first, first in first
// out among equal priorities. Each request beat enqueues or dequeues; each
// gives one response beat with the status, the head entry and the fill count
// after the step. A request is taken every cycle while the response register
// is free or being drained, and its response appears in the next cycle: every
// slot compares its priority against the new one in parallel and shifts in
// the same cycle. No clearing pass follows reset; the queue starts empty.
module stable_priority_queue_core
	import spq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire logic req_valid,
	output logic      req_stall,
	output rsp_t      rsp,
	output logic      rsp_valid,
	input  wire logic rsp_stall
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             accept;
	logic             full;
	logic             empty;
	cell_ctl_t        ctl;
	status_t          status;

	entry_t           cell_entry [QUEUE_DEPTH];
	entry_t           cell_next  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_ge;
	logic [QUEUE_DEPTH-1:0] cell_occ;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	always_comb begin
		ctl.enq        = accept && (req.action == ACT_ENQ) && !full;
		ctl.deq        = accept && (req.action == ACT_DEQ) && !empty;
		ctl.entry.data = req.item_data;
		ctl.entry.prio = req.item_priority;
	end

	always_comb begin
		status  = ST_DONE;
		count_d = count_q;
		case (req.action)
			ACT_ENQ: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			ACT_DEQ: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_entry;
		entry_t right_entry;
		logic   left_ge;

		assign cell_occ[i] = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign left_entry = ctl.entry;
			assign left_ge    = 1'b1;
		end else begin : g_body
			assign left_entry = cell_entry[i-1];
			assign left_ge    = cell_ge[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_mid
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (cell_occ[i]),
			.left_ge     (left_ge),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (cell_entry[i]),
			.entry_d     (cell_next[i]),
			.ge          (cell_ge[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status        <= status;
			rsp_q.head_valid    <= (count_d != '0);
			rsp_q.head_data     <= (count_d != '0) ? cell_next[0].data : '0;
			rsp_q.head_priority <= (count_d != '0) ? cell_next[0].prio : '0;
			rsp_q.fill_count    <= FILL_W'(count_d);
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
	`SPQ_ASSERT_NEXT(a_full_refused, accept && (req.action == ACT_ENQ) && full, rsp_q.status == ST_FULL && full)
	`SPQ_ASSERT_NOW(a_head_order, cell_occ[1], cell_entry[0].prio >= cell_entry[1].prio)
	`SPQ_ASSERT_NOW(a_head_matches_count, rsp_valid_q, rsp_q.head_valid == (count_q != '0))

endmodule

`default_nettype wire
